[sv/tams_pkg.sv]
// tams_pkg: shared widths, constants and word types of the two-axis move speed split
// no dependencies; imported by every module of the block

package tams_pkg;

  localparam int PosBits   = 24;
  localparam int SpeedBits = 13;
  localparam int TimeBits  = 40;
  // axis quotient before final rounding, at most twice the max speed
  localparam int KBits     = 14;

  localparam logic [SpeedBits-1:0] SpeedReset = 13'd2000;

  typedef struct packed {
    logic signed [PosBits-1:0] x_dist;
    logic signed [PosBits-1:0] y_dist;
  } move_in_t;

  typedef struct packed {
    logic [TimeBits-1:0]       move_time;
    logic [SpeedBits-1:0]      x_speed;
    logic [SpeedBits-1:0]      y_speed;
    logic signed [PosBits-1:0] x_out;
    logic signed [PosBits-1:0] y_out;
  } move_out_t;

endpackage

[sv/tams_prep.sv]
// tams_prep: five-stage front end, magnitudes, squared length, scaled square for the root
// and squared axis targets for the speed cells; depends on tams_pkg

module tams_prep #(
  parameter int SW   = 48,
  parameter int ZW   = 77,
  parameter int MW   = 38,
  parameter int RW   = 76,
  parameter int T2W  = 29,
  parameter longint unsigned T2 = 64'd400000000
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              vld_i,
  output logic                              rdy_o,
  output logic                              vld_o,
  input  logic                              rdy_i,
  input  logic [1:0][tams_pkg::PosBits-1:0]   pos_i,
  input  logic [tams_pkg::SpeedBits-1:0]      ms_i,
  output logic [ZW-1:0]                     z_o,
  output logic [SW-1:0]                     s_o,
  output logic [1:0][RW-1:0]                r_o,
  output logic                              sz_o,
  output logic [1:0][tams_pkg::PosBits-1:0]   pos_o,
  output logic [tams_pkg::SpeedBits-1:0]      ms_o
);
  import tams_pkg::*;

  localparam int NS  = 5;
  localparam int H   = MW / 2;
  localparam int HW  = MW - H;
  localparam int SH  = SW / 2;
  localparam int ZHW = T2W + SW - SH;
  localparam int ZLW = T2W + SH;

  logic [NS-1:0] vld_q;
  logic [NS-1:0] st_rdy;
  logic [NS-1:0] vin;

  logic [1:0][PosBits-1:0]   mag_d;
  logic [1:0][PosBits-1:0]   ax0_q, pos0_q, pos1_q, pos2_q, pos3_q, pos4_q;
  logic [SpeedBits-1:0]      ms0_q, ms1_q, ms2_q, ms3_q, ms4_q;
  logic [1:0][SW-1:0]        sq1_q;
  logic [1:0][MW-1:0]        m1_q;
  logic [SW-1:0]             s2_q, s3_q, s4_q;
  logic [1:0][2*HW-1:0]      hh2_q;
  logic [1:0][MW-1:0]        hl2_q;
  logic [1:0][2*H-1:0]       ll2_q;
  logic [ZHW-1:0]            zh3_q;
  logic [ZLW-1:0]            zl3_q;
  logic [1:0][RW-1:0]        r3_q, r4_q;
  logic                      sz3_q, sz4_q;
  logic [ZW-1:0]             z4_q;

  assign vin = {vld_q[NS-2:0], vld_i};

  genvar g;
  for (g = 0; g < NS; g++) begin : g_rdy
    if (g == NS - 1) begin : g_last
      assign st_rdy[g] = ~vld_q[g] | rdy_i;
    end else begin : g_mid
      assign st_rdy[g] = ~vld_q[g] | st_rdy[g+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int i = 0; i < NS; i++) begin
        if (st_rdy[i]) vld_q[i] <= vin[i];
      end
    end
  end

  // two's complement magnitude, the most negative value maps to its unsigned twin
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      mag_d[l] = pos_i[l][PosBits-1] ? PosBits'(~pos_i[l] + 1'b1) : pos_i[l];
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_rdy[0]) begin
      ax0_q  <= mag_d;
      pos0_q <= pos_i;
      ms0_q  <= ms_i;
    end
    if (st_rdy[1]) begin
      for (int l = 0; l < 2; l++) begin
        sq1_q[l] <= SW'(ax0_q[l]) * SW'(ax0_q[l]);
        m1_q[l]  <= (MW'(ax0_q[l]) * MW'(ms0_q)) << 1;
      end
      pos1_q <= pos0_q;
      ms1_q  <= ms0_q;
    end
    if (st_rdy[2]) begin
      s2_q <= sq1_q[0] + sq1_q[1];
      for (int l = 0; l < 2; l++) begin
        hh2_q[l] <= (2*HW)'(m1_q[l][MW-1:H]) * (2*HW)'(m1_q[l][MW-1:H]);
        hl2_q[l] <= MW'(m1_q[l][MW-1:H]) * MW'(m1_q[l][H-1:0]);
        ll2_q[l] <= (2*H)'(m1_q[l][H-1:0]) * (2*H)'(m1_q[l][H-1:0]);
      end
      pos2_q <= pos1_q;
      ms2_q  <= ms1_q;
    end
    if (st_rdy[3]) begin
      zh3_q <= ZHW'(T2) * ZHW'(s2_q[SW-1:SH]);
      zl3_q <= ZLW'(T2) * ZLW'(s2_q[SH-1:0]);
      for (int l = 0; l < 2; l++) begin
        r3_q[l] <= (RW'(hh2_q[l]) << (2*H)) + (RW'(hl2_q[l]) << (H+1)) + RW'(ll2_q[l]);
      end
      s3_q   <= s2_q;
      sz3_q  <= (s2_q == '0);
      pos3_q <= pos2_q;
      ms3_q  <= ms2_q;
    end
    if (st_rdy[4]) begin
      z4_q   <= (ZW'(zh3_q) << SH) + ZW'(zl3_q);
      r4_q   <= r3_q;
      s4_q   <= s3_q;
      sz4_q  <= sz3_q;
      pos4_q <= pos3_q;
      ms4_q  <= ms3_q;
    end
  end

  assign rdy_o = st_rdy[0];
  assign vld_o = vld_q[NS-1];
  assign z_o   = z4_q;
  assign s_o   = s4_q;
  assign r_o   = r4_q;
  assign sz_o  = sz4_q;
  assign pos_o = pos4_q;
  assign ms_o  = ms4_q;

endmodule

[sv/tams_spd_cell.sv]
// tams_spd_cell: one bit of the axis speed quotient for both axes, largest k with
// k*k*s <= r, kept exact through running k*k*s and k*s; depends on tams_pkg

module tams_spd_cell #(
  parameter int SW  = 48,
  parameter int RW  = 76,
  parameter int BIT = 0,
  parameter int SDW = 1
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             vld_i,
  output logic                             rdy_o,
  output logic                             vld_o,
  input  logic                             rdy_i,
  input  logic [SW-1:0]                    s_i,
  input  logic [1:0][RW-1:0]               r_i,
  input  logic [1:0][RW-1:0]               p_i,
  input  logic [1:0][RW-1:0]               q_i,
  input  logic [1:0][tams_pkg::KBits-1:0]  k_i,
  input  logic [SDW-1:0]                   sd_i,
  output logic [SW-1:0]                    s_o,
  output logic [1:0][RW-1:0]               r_o,
  output logic [1:0][RW-1:0]               p_o,
  output logic [1:0][RW-1:0]               q_o,
  output logic [1:0][tams_pkg::KBits-1:0]  k_o,
  output logic [SDW-1:0]                   sd_o
);
  import tams_pkg::*;

  logic                    vld_q;
  logic [1:0][RW-1:0]      t;
  logic [1:0]              take;
  logic [SW-1:0]           s_q;
  logic [1:0][RW-1:0]      r_q, p_q, q_q;
  logic [1:0][KBits-1:0]   k_q;
  logic [SDW-1:0]          sd_q;

  // (k + 2^b)^2 * s = k^2 s + 2^(b+1) k s + 2^(2b) s
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      t[l]    = p_i[l] + (q_i[l] << (BIT + 1)) + (RW'(s_i) << (2 * BIT));
      take[l] = (t[l] <= r_i[l]);
    end
  end

  assign rdy_o = ~vld_q | rdy_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (rdy_o) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_o) begin
      s_q  <= s_i;
      r_q  <= r_i;
      sd_q <= sd_i;
      for (int l = 0; l < 2; l++) begin
        p_q[l] <= take[l] ? t[l] : p_i[l];
        q_q[l] <= take[l] ? q_i[l] + (RW'(s_i) << BIT) : q_i[l];
        k_q[l] <= take[l] ? (k_i[l] | (KBits'(1) << BIT)) : k_i[l];
      end
    end
  end

  assign vld_o = vld_q;
  assign s_o   = s_q;
  assign r_o   = r_q;
  assign p_o   = p_q;
  assign q_o   = q_q;
  assign k_o   = k_q;
  assign sd_o  = sd_q;

endmodule

[sv/tams_sqrt_cell.sv]
// tams_sqrt_cell: one root bit of a restoring integer square root
// depends on tams_pkg

module tams_sqrt_cell #(
  parameter int NW  = 39,
  parameter int BIT = 0,
  parameter int SDW = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              vld_i,
  output logic              rdy_o,
  output logic              vld_o,
  input  logic              rdy_i,
  input  logic [2*NW:0]     rem_i,
  input  logic [NW-1:0]     root_i,
  input  logic [SDW-1:0]    sd_i,
  output logic [2*NW:0]     rem_o,
  output logic [NW-1:0]     root_o,
  output logic [SDW-1:0]    sd_o
);
  import tams_pkg::*;

  localparam int RMW = 2 * NW + 1;

  logic              vld_q;
  logic [RMW-1:0]    d;
  logic              take;
  logic [RMW-1:0]    rem_q;
  logic [NW-1:0]     root_q;
  logic [SDW-1:0]    sd_q;

  assign d    = (RMW'(root_i) << (BIT + 1)) | (RMW'(1) << (2 * BIT));
  assign take = (rem_i >= d);

  assign rdy_o = ~vld_q | rdy_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (rdy_o) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_o) begin
      rem_q  <= take ? rem_i - d : rem_i;
      root_q <= take ? (root_i | (NW'(1) << BIT)) : root_i;
      sd_q   <= sd_i;
    end
  end

  assign vld_o  = vld_q;
  assign rem_o  = rem_q;
  assign root_o = root_q;
  assign sd_o   = sd_q;

endmodule

[sv/tams_div_cell.sv]
// tams_div_cell: one quotient bit of a restoring divide of the root by the max speed
// depends on tams_pkg

module tams_div_cell #(
  parameter int NW  = 39,
  parameter int BIT = 0,
  parameter int SDW = 1
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             vld_i,
  output logic                             rdy_o,
  output logic                             vld_o,
  input  logic                             rdy_i,
  input  logic [NW-1:0]                    num_i,
  input  logic [tams_pkg::SpeedBits-1:0]   den_i,
  input  logic [tams_pkg::SpeedBits-1:0]   rem_i,
  input  logic [NW-1:0]                    quo_i,
  input  logic [SDW-1:0]                   sd_i,
  output logic [NW-1:0]                    num_o,
  output logic [tams_pkg::SpeedBits-1:0]   den_o,
  output logic [tams_pkg::SpeedBits-1:0]   rem_o,
  output logic [NW-1:0]                    quo_o,
  output logic [SDW-1:0]                   sd_o
);
  import tams_pkg::*;

  logic                   vld_q;
  logic [SpeedBits:0]     t;
  logic [SpeedBits:0]     diff;
  logic                   take;
  logic [NW-1:0]          num_q, quo_q;
  logic [SpeedBits-1:0]   den_q, rem_q;
  logic [SDW-1:0]         sd_q;

  assign t    = {rem_i, num_i[BIT]};
  assign diff = t - {1'b0, den_i};
  assign take = (t >= {1'b0, den_i});

  assign rdy_o = ~vld_q | rdy_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (rdy_o) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_o) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= take ? diff[SpeedBits-1:0] : t[SpeedBits-1:0];
      quo_q <= take ? (quo_i | (NW'(1) << BIT)) : quo_i;
      sd_q  <= sd_i;
    end
  end

  assign vld_o = vld_q;
  assign num_o = num_q;
  assign den_o = den_q;
  assign rem_o = rem_q;
  assign quo_o = quo_q;
  assign sd_o  = sd_q;

endmodule

[sv/two_axis_move_speed_split.sv]
// two_axis_move_speed_split: straight-line two-axis move split into time and axis speeds
// 5 + 14 + 2*RTW + 1 register stages, 98 at TIME_SCALE 10000; throughput one word per cycle
// while out_ready_i drains the output, a cell stalls only when full
// rtw root cells then rtw divide cells set the depth, rtw = half the width of 4*ts^2*L^2
// async active-low reset empties the pipe and loads max_speed with 2000
// depends on tams_pkg, tams_prep, tams_spd_cell, tams_sqrt_cell, tams_div_cell

module two_axis_move_speed_split #(
  parameter int TIME_SCALE = 10000
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  tams_pkg::move_in_t             in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output tams_pkg::move_out_t            out_data_o,
  input  logic                           cfg_we_i,
  input  logic [tams_pkg::SpeedBits-1:0] cfg_wdata_i
);
  import tams_pkg::*;

  // squared scale for the root: root = floor(2 * TIME_SCALE * L)
  localparam longint unsigned T2 = 64'd4 * 64'(TIME_SCALE) * 64'(TIME_SCALE);
  localparam int T2W  = $clog2(T2 + 64'd1);
  localparam int SW   = 2 * PosBits;
  localparam int ZW   = SW + T2W;
  localparam int RTW  = (ZW + 1) / 2;
  localparam int MW   = PosBits + KBits;
  localparam int RW   = 2 * MW;
  localparam int NC   = KBits + 2 * RTW;
  localparam int TEW  = (RTW > TimeBits) ? RTW : TimeBits;
  localparam int SD1W = 2 * PosBits + SpeedBits + ZW + 1;
  localparam int SD2W = 2 * PosBits + SpeedBits + 2 * KBits + 1;
  localparam int SD3W = 2 * PosBits + 2 * KBits + 1;

  // config register, zero speed behaves as one
  logic [SpeedBits-1:0] max_speed_q;
  logic [SpeedBits-1:0] ms_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_speed_q <= SpeedReset;
    end else if (cfg_we_i) begin
      max_speed_q <= cfg_wdata_i;
    end
  end

  assign ms_eff = (max_speed_q == '0) ? SpeedBits'(1) : max_speed_q;

  // handshake chain through all cells, c_vld[j] feeds cell j
  logic [NC:0] c_vld;
  logic [NC:0] c_rdy;

  // front end
  logic [1:0][PosBits-1:0] pp_pos;
  logic [ZW-1:0]           pp_z;
  logic [SW-1:0]           pp_s;
  logic [1:0][RW-1:0]      pp_r;
  logic                    pp_sz;
  logic [SpeedBits-1:0]    pp_ms;

  tams_prep #(
    .SW  (SW),
    .ZW  (ZW),
    .MW  (MW),
    .RW  (RW),
    .T2W (T2W),
    .T2  (T2)
  ) u_prep (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (in_valid_i),
    .rdy_o  (in_ready_o),
    .vld_o  (c_vld[0]),
    .rdy_i  (c_rdy[0]),
    .pos_i  ({in_data_i.x_dist, in_data_i.y_dist}),
    .ms_i   (ms_eff),
    .z_o    (pp_z),
    .s_o    (pp_s),
    .r_o    (pp_r),
    .sz_o   (pp_sz),
    .pos_o  (pp_pos),
    .ms_o   (pp_ms)
  );

  // axis speed cells: k = floor(2*|a|*ms / L), one bit per cell, msb first
  logic [SW-1:0]            sp_s  [KBits+1];
  logic [1:0][RW-1:0]       sp_r  [KBits+1];
  logic [1:0][RW-1:0]       sp_p  [KBits+1];
  logic [1:0][RW-1:0]       sp_q  [KBits+1];
  logic [1:0][KBits-1:0]    sp_k  [KBits+1];
  logic [SD1W-1:0]          sp_sd [KBits+1];

  assign sp_s[0]  = pp_s;
  assign sp_r[0]  = pp_r;
  assign sp_p[0]  = '0;
  assign sp_q[0]  = '0;
  assign sp_k[0]  = '0;
  assign sp_sd[0] = {pp_pos, pp_ms, pp_z, pp_sz};

  genvar j;
  for (j = 0; j < KBits; j++) begin : g_spd
    tams_spd_cell #(
      .SW  (SW),
      .RW  (RW),
      .BIT (KBits - 1 - j),
      .SDW (SD1W)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .vld_i  (c_vld[j]),
      .rdy_o  (c_rdy[j]),
      .vld_o  (c_vld[j+1]),
      .rdy_i  (c_rdy[j+1]),
      .s_i    (sp_s[j]),
      .r_i    (sp_r[j]),
      .p_i    (sp_p[j]),
      .q_i    (sp_q[j]),
      .k_i    (sp_k[j]),
      .sd_i   (sp_sd[j]),
      .s_o    (sp_s[j+1]),
      .r_o    (sp_r[j+1]),
      .p_o    (sp_p[j+1]),
      .q_o    (sp_q[j+1]),
      .k_o    (sp_k[j+1]),
      .sd_o   (sp_sd[j+1])
    );
  end

  logic [1:0][PosBits-1:0] sp_pos;
  logic [SpeedBits-1:0]    sp_ms;
  logic [ZW-1:0]           sp_z;
  logic                    sp_sz;

  assign {sp_pos, sp_ms, sp_z, sp_sz} = sp_sd[KBits];

  // square root cells on the scaled squared length
  logic [2*RTW:0]   sq_rem  [RTW+1];
  logic [RTW-1:0]   sq_root [RTW+1];
  logic [SD2W-1:0]  sq_sd   [RTW+1];

  assign sq_rem[0]  = (2*RTW+1)'(sp_z);
  assign sq_root[0] = '0;
  assign sq_sd[0]   = {sp_pos, sp_ms, sp_k[KBits], sp_sz};

  for (j = 0; j < RTW; j++) begin : g_sqrt
    tams_sqrt_cell #(
      .NW  (RTW),
      .BIT (RTW - 1 - j),
      .SDW (SD2W)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .vld_i  (c_vld[KBits+j]),
      .rdy_o  (c_rdy[KBits+j]),
      .vld_o  (c_vld[KBits+j+1]),
      .rdy_i  (c_rdy[KBits+j+1]),
      .rem_i  (sq_rem[j]),
      .root_i (sq_root[j]),
      .sd_i   (sq_sd[j]),
      .rem_o  (sq_rem[j+1]),
      .root_o (sq_root[j+1]),
      .sd_o   (sq_sd[j+1])
    );
  end

  logic [1:0][PosBits-1:0] sq_pos;
  logic [SpeedBits-1:0]    sq_ms;
  logic [1:0][KBits-1:0]   sq_k;
  logic                    sq_sz;

  assign {sq_pos, sq_ms, sq_k, sq_sz} = sq_sd[RTW];

  // divide cells: root / max_speed
  logic [RTW-1:0]        dv_num [RTW+1];
  logic [SpeedBits-1:0]  dv_den [RTW+1];
  logic [SpeedBits-1:0]  dv_rem [RTW+1];
  logic [RTW-1:0]        dv_quo [RTW+1];
  logic [SD3W-1:0]       dv_sd  [RTW+1];

  assign dv_num[0] = sq_root[RTW];
  assign dv_den[0] = sq_ms;
  assign dv_rem[0] = '0;
  assign dv_quo[0] = '0;
  assign dv_sd[0]  = {sq_pos, sq_k, sq_sz};

  for (j = 0; j < RTW; j++) begin : g_div
    tams_div_cell #(
      .NW  (RTW),
      .BIT (RTW - 1 - j),
      .SDW (SD3W)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .vld_i  (c_vld[KBits+RTW+j]),
      .rdy_o  (c_rdy[KBits+RTW+j]),
      .vld_o  (c_vld[KBits+RTW+j+1]),
      .rdy_i  (c_rdy[KBits+RTW+j+1]),
      .num_i  (dv_num[j]),
      .den_i  (dv_den[j]),
      .rem_i  (dv_rem[j]),
      .quo_i  (dv_quo[j]),
      .sd_i   (dv_sd[j]),
      .num_o  (dv_num[j+1]),
      .den_o  (dv_den[j+1]),
      .rem_o  (dv_rem[j+1]),
      .quo_o  (dv_quo[j+1]),
      .sd_o   (dv_sd[j+1])
    );
  end

  logic [1:0][PosBits-1:0] dv_pos;
  logic [1:0][KBits-1:0]   dv_k;
  logic                    dv_sz;

  assign {dv_pos, dv_k, dv_sz} = dv_sd[RTW];

  // final rounding: halve with ties up, saturate time, zero move gives zero speeds
  logic [TEW:0]       tm_full;
  logic [TEW-1:0]     tm;
  logic [KBits:0]     kx_r, ky_r;
  move_out_t          out_d;
  move_out_t          out_q;
  logic               out_vld_q;
  logic               out_rdy;

  always_comb begin
    tm_full = (TEW+1)'(dv_quo[RTW]) + (TEW+1)'(1);
    tm      = tm_full[TEW:1];
    kx_r    = (KBits+1)'(dv_k[1]) + (KBits+1)'(1);
    ky_r    = (KBits+1)'(dv_k[0]) + (KBits+1)'(1);
    out_d.move_time = (tm > TEW'({TimeBits{1'b1}})) ? '1 : tm[TimeBits-1:0];
    out_d.x_speed   = dv_sz ? '0 : kx_r[SpeedBits:1];
    out_d.y_speed   = dv_sz ? '0 : ky_r[SpeedBits:1];
    out_d.x_out     = dv_pos[1];
    out_d.y_out     = dv_pos[0];
  end

  // output register, takes a new word whenever empty or being drained
  assign out_rdy   = ~out_vld_q | out_ready_i;
  assign c_rdy[NC] = out_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_rdy) begin
      out_vld_q <= c_vld[NC];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_rdy) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

[sv/tams_chk.sv]
// tams_chk: port-level checks of the two-axis move speed split, bound to the top level
// depends on tams_pkg and two_axis_move_speed_split

module tams_chk (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input tams_pkg::move_out_t  out_data_o
);
  import tams_pkg::*;

  // a held result word stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result word changed while stalled");

  // an axis that does not move has no speed
  a_x_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.x_out == '0 |-> out_data_o.x_speed == '0)
    else $error("x speed on a still x axis");

  a_y_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.y_out == '0 |-> out_data_o.y_speed == '0)
    else $error("y speed on a still y axis");

  // a pure y move runs y at the full path speed; checked here only as never zero
  a_y_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.x_out == '0 && out_data_o.y_out != '0
      |-> out_data_o.y_speed != '0)
    else $error("pure y move with zero speed");

endmodule

bind two_axis_move_speed_split tams_chk u_tams_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
